[rtl/stq_pkg.sv]
// Shared types and constants for the sorted timestamp queue.
package stq_pkg;

	localparam int STAMP_W = 64;
	localparam int OCC_W   = 7;

	localparam logic [STAMP_W-1:0] NO_STAMP = {1'b1, {(STAMP_W-1){1'b0}}};

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_POP    = 2'd1,
		CMD_CLEAR  = 2'd2
	} cmd_t;

	typedef struct packed {
		logic ins;
		logic pop;
	} stq_ctl_t;

endpackage

[rtl/sorted_timestamp_queue_core.sv]
// Top level of the sorted timestamp queue: a row of compare-and-shift cells.
//
//   channel   signals                                          direction
//   command   cmd_valid, cmd_ready, cmd, stamp                 in
//   result    result_valid, result_ready, popped_stamp,        out
//             popped_valid, dropped, occupancy
//
// One command word per cycle is sustained while the result register is drained.
// The broadcast compare in each cell and the shift to the neighbor set that figure.
// A command word is taken while the result register is empty or being drained.
// Reset clears the fill count and the result valid; cell contents stay undefined.
// A stalled result holds its word and blocks only the next command.
module sorted_timestamp_queue_core import stq_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cmd_valid,
	output logic                      cmd_ready,
	input  logic [1:0]                cmd,
	input  logic signed [STAMP_W-1:0] stamp,
	output logic                      result_valid,
	input  logic                      result_ready,
	output logic signed [STAMP_W-1:0] popped_stamp,
	output logic                      popped_valid,
	output logic                      dropped,
	output logic [OCC_W-1:0]          occupancy
);

	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0]             count_q;
	logic [CW-1:0]             count_d;
	logic                      fire;
	logic                      full;
	logic                      empty;
	logic                      is_marker;
	logic                      pop_v;
	logic                      drop_v;
	stq_ctl_t                  ctl;
	logic [DEPTH-1:0]          gt;
	logic signed [STAMP_W-1:0] vals [DEPTH];
	logic [CW+OCC_W-1:0]       count_ext;

	logic                      result_valid_q;
	logic signed [STAMP_W-1:0] popped_stamp_q;
	logic                      popped_valid_q;
	logic                      dropped_q;
	logic [OCC_W-1:0]          occupancy_q;

	assign cmd_ready = !result_valid_q || result_ready;
	assign fire      = cmd_valid && cmd_ready;
	assign full      = (count_q == CW'(DEPTH));
	assign empty     = (count_q == '0);
	assign is_marker = (stamp == NO_STAMP);

	always_comb begin
		ctl     = '0;
		pop_v   = 1'b0;
		drop_v  = 1'b0;
		count_d = count_q;
		case (cmd)
			CMD_INSERT: begin
				if (!is_marker) begin
					if (full) begin
						drop_v = 1'b1;
					end else begin
						ctl.ins = fire;
						count_d = count_q + CW'(1);
					end
				end
			end
			CMD_POP: begin
				if (!empty) begin
					pop_v   = 1'b1;
					ctl.pop = fire;
					count_d = count_q - CW'(1);
				end
			end
			CMD_CLEAR: begin
				count_d = '0;
			end
			default: begin
				count_d = count_q;
			end
		endcase
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                      occ_i;
		logic                      free_i;
		logic                      lgt_i;
		logic signed [STAMP_W-1:0] lval_i;
		logic signed [STAMP_W-1:0] rval_i;

		assign occ_i  = (count_q > CW'(i));
		assign free_i = (count_q == CW'(i));

		if (i == 0) begin : g_first
			assign lgt_i  = 1'b0;
			assign lval_i = '0;
		end else begin : g_mid
			assign lgt_i  = gt[i-1];
			assign lval_i = vals[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign rval_i = '0;
		end else begin : g_notlast
			assign rval_i = vals[i+1];
		end

		stq_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.stamp      (stamp),
			.occupied   (occ_i),
			.first_free (free_i),
			.left_gt    (lgt_i),
			.left_val   (lval_i),
			.right_val  (rval_i),
			.gt         (gt[i]),
			.val        (vals[i])
		);
	end

	assign count_ext = {{OCC_W{1'b0}}, count_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				count_q        <= count_d;
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			popped_stamp_q <= pop_v ? vals[0] : NO_STAMP;
			popped_valid_q <= pop_v;
			dropped_q      <= drop_v;
			occupancy_q    <= count_ext[OCC_W-1:0];
		end
	end

	assign result_valid = result_valid_q;
	assign popped_stamp = popped_stamp_q;
	assign popped_valid = popped_valid_q;
	assign dropped      = dropped_q;
	assign occupancy    = occupancy_q;

endmodule

[rtl/stq_cell.sv]
// One cell of the sorted row: holds one timestamp and shifts with its neighbors.
module stq_cell import stq_pkg::*; (
	input  logic                      clk,
	input  stq_ctl_t                  ctl,
	input  logic signed [STAMP_W-1:0] stamp,
	input  logic                      occupied,
	input  logic                      first_free,
	input  logic                      left_gt,
	input  logic signed [STAMP_W-1:0] left_val,
	input  logic signed [STAMP_W-1:0] right_val,
	output logic                      gt,
	output logic signed [STAMP_W-1:0] val
);

	logic signed [STAMP_W-1:0] val_q;

	assign gt  = occupied && (val_q > stamp);
	assign val = val_q;

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (left_gt) begin
				val_q <= left_val;
			end else if (gt || first_free) begin
				val_q <= stamp;
			end
		end else if (ctl.pop) begin
			val_q <= right_val;
		end
	end

endmodule

[rtl/stq_checker.sv]
// Port-level checks for the sorted timestamp queue and their bind to the top level.
module stq_checker import stq_pkg::*; #(
	parameter int DEPTH = 64
) (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      result_valid,
	input logic                      result_ready,
	input logic signed [STAMP_W-1:0] popped_stamp,
	input logic                      popped_valid,
	input logic                      dropped,
	input logic [OCC_W-1:0]          occupancy
);

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(popped_stamp)
			&& $stable(occupancy))
		else $error("Stalled result word changed.");

	a_pop_not_drop: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(popped_valid && dropped))
		else $error("A result word is both a pop and a drop.");

	a_marker_iff_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (popped_valid == (popped_stamp != NO_STAMP)))
		else $error("Popped stamp and popped valid disagree.");

	a_drop_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && dropped && DEPTH < 128 |-> occupancy == OCC_W'(DEPTH))
		else $error("Insert dropped while the store was not full.");

endmodule

bind sorted_timestamp_queue_core stq_checker #(.DEPTH(DEPTH)) u_stq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.popped_stamp (popped_stamp),
	.popped_valid (popped_valid),
	.dropped      (dropped),
	.occupancy    (occupancy)
);

[dv/sorted_timestamp_queue_checker.sv]
// Checker for the sorted timestamp queue: tracks the stored stamps and compares each result word.
module sorted_timestamp_queue_checker import stq_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cmd_valid,
	input  logic                      cmd_ready,
	input  logic [1:0]                cmd,
	input  logic signed [STAMP_W-1:0] stamp,
	input  logic                      result_valid,
	input  logic                      result_ready,
	input  logic signed [STAMP_W-1:0] popped_stamp,
	input  logic                      popped_valid,
	input  logic                      dropped,
	input  logic [OCC_W-1:0]          occupancy,
	output int                        fail_count,
	output int                        pending_count
);

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [STAMP_W-1:0] popped_stamp;
		logic                      popped_valid;
		logic                      dropped;
		logic [OCC_W-1:0]          occupancy;
	} queue_result_t;

	logic signed [STAMP_W-1:0] ordered_stamps[$];
	queue_result_t             expected_words[$];
	queue_result_t             oldest_word;

	function automatic queue_result_t apply_queue_command(input logic [1:0] op,
			input logic signed [STAMP_W-1:0] value);
		queue_result_t res;
		int pos;
		int fill;
		res.popped_stamp = NO_STAMP;
		res.popped_valid = 1'b0;
		res.dropped      = 1'b0;
		pos              = 0;
		case (op)
			CMD_INSERT: begin
				if (value != NO_STAMP) begin
					if (ordered_stamps.size() >= DEPTH) begin
						res.dropped = 1'b1;
					end else begin
						// Equal stamps keep their arrival order.
						while (pos < ordered_stamps.size() && ordered_stamps[pos] <= value)
							pos++;
						ordered_stamps.insert(pos, value);
					end
				end
			end
			CMD_POP: begin
				if (ordered_stamps.size() > 0) begin
					res.popped_stamp = ordered_stamps.pop_front();
					res.popped_valid = 1'b1;
				end
			end
			CMD_CLEAR: begin
				ordered_stamps.delete();
			end
			default: begin
			end
		endcase
		fill          = ordered_stamps.size();
		res.occupancy = fill[OCC_W-1:0];
		return res;
	endfunction

	task automatic check_field(input string name, input logic [STAMP_W-1:0] want,
			input logic [STAMP_W-1:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %h, actual %h", name, want, got);
			fail_count++;
		end
	endtask

	initial begin
		fail_count    = 0;
		pending_count = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ordered_stamps.delete();
			expected_words.delete();
		end else begin
			if (result_valid && result_ready) begin
				if (expected_words.size() == 0) begin
					$error("result word accepted with no command outstanding");
					fail_count++;
				end else begin
					oldest_word = expected_words.pop_front();
					check_field("popped_stamp", oldest_word.popped_stamp, popped_stamp);
					check_field("popped_valid", oldest_word.popped_valid, popped_valid);
					check_field("dropped", oldest_word.dropped, dropped);
					check_field("occupancy", oldest_word.occupancy, occupancy);
				end
			end
			if (cmd_valid && cmd_ready)
				expected_words.push_back(apply_queue_command(cmd, stamp));
		end
		pending_count = expected_words.size();
	end

endmodule

[dv/sorted_timestamp_queue_core_tb.sv]
// Testbench top for the sorted timestamp queue: clock, reset, command stimulus and verdict.
module sorted_timestamp_queue_core_tb import stq_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 64;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [STAMP_W-1:0] STAMP_MAX = {1'b0, {(STAMP_W-1){1'b1}}};
	localparam logic [STAMP_W-1:0] STAMP_LOWEST = NO_STAMP + 1;
	localparam int ITEMS_PER_PHASE = 175;
	localparam int HOLD_CYCLES = 300;

	logic                      clk;
	logic                      arst_n;
	logic                      cmd_valid;
	logic                      cmd_ready;
	logic [1:0]                cmd;
	logic signed [STAMP_W-1:0] stamp;
	logic                      result_valid;
	logic                      result_ready;
	logic signed [STAMP_W-1:0] popped_stamp;
	logic                      popped_valid;
	logic                      dropped;
	logic [OCC_W-1:0]          occupancy;
	int                        fail_count;
	int                        pending_count;

	int sender_idle_pct;
	int stall_pct;
	int hold_requests;
	int items_sent;

	sorted_timestamp_queue_core #(
		.DEPTH(DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.stamp(stamp),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.popped_stamp(popped_stamp),
		.popped_valid(popped_valid),
		.dropped(dropped),
		.occupancy(occupancy)
	);

	sorted_timestamp_queue_checker #(
		.DEPTH(DEPTH)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.stamp(stamp),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.popped_stamp(popped_stamp),
		.popped_valid(popped_valid),
		.dropped(dropped),
		.occupancy(occupancy),
		.fail_count(fail_count),
		.pending_count(pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end

	// The receiver serves a long hold-off whenever the stimulus asks for one and otherwise stalls at random.
	initial begin
		int holds_served;
		int hold_left;
		holds_served = 0;
		hold_left    = 0;
		result_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (holds_served != hold_requests) begin
				holds_served++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ready = 1'b0;
			end else begin
				result_ready = ($urandom_range(99) >= stall_pct);
			end
		end
	end

	function automatic logic [STAMP_W-1:0] pick_stamp();
		int near_zero;
		near_zero = int'($urandom_range(15)) - 8;
		case ($urandom_range(3))
			0: return {$urandom, $urandom};
			1: return {{32{near_zero[31]}}, near_zero};
			2: begin
				case ($urandom_range(3))
					0: return STAMP_MAX;
					1: return STAMP_LOWEST;
					2: return '0;
					default: return '1;
				endcase
			end
			default: return {32'h0, $urandom};
		endcase
	endfunction

	task automatic send_word(input logic [1:0] op, input logic [STAMP_W-1:0] value);
		while ($urandom_range(99) < sender_idle_pct) begin
			cmd_valid = 1'b0;
			@(negedge clk);
		end
		cmd_valid = 1'b1;
		cmd       = op;
		stamp     = value;
		do @(posedge clk); while (cmd_ready !== 1'b1);
		if (!(op == CMD_UNUSED || (op == CMD_INSERT && value == NO_STAMP)))
			items_sent++;
		@(negedge clk);
	endtask

	task automatic wait_for_results();
		cmd_valid = 1'b0;
		while (pending_count != 0)
			@(negedge clk);
	endtask

	task automatic fill_and_drain();
		repeat (DEPTH + 3)
			send_word(CMD_INSERT, pick_stamp());
		send_word(CMD_INSERT, NO_STAMP);
		repeat (DEPTH + 3)
			send_word(CMD_POP, pick_stamp());
	endtask

	initial begin
		int phase;
		int burst;
		int kind;
		arst_n          = 1'b0;
		cmd_valid       = 1'b0;
		cmd             = CMD_INSERT;
		stamp           = '0;
		sender_idle_pct = 0;
		stall_pct       = 0;
		hold_requests   = 0;
		items_sent      = 0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_word(CMD_INSERT, STAMP_MAX);
		send_word(CMD_INSERT, STAMP_LOWEST);
		send_word(CMD_INSERT, '0);
		send_word(CMD_INSERT, '1);
		send_word(CMD_INSERT, 64'sd5);
		send_word(CMD_INSERT, 64'sd5);
		send_word(CMD_INSERT, NO_STAMP);
		repeat (6) send_word(CMD_POP, '0);
		send_word(CMD_POP, '1);
		send_word(CMD_INSERT, 64'sd3);
		send_word(CMD_UNUSED, STAMP_MAX);
		send_word(CMD_CLEAR, '1);
		send_word(CMD_POP, '0);
		send_word(CMD_INSERT, 64'sd7);
		send_word(CMD_CLEAR, '0);
		send_word(CMD_INSERT, {$urandom, $urandom});
		send_word(CMD_POP, '0);
		wait_for_results();

		for (phase = 0; phase < 4; phase++) begin
			@(posedge clk);
			case (phase)
				0: begin sender_idle_pct = 0;  stall_pct = 0;  end
				1: begin sender_idle_pct = 85; stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  stall_pct = 85; end
				default: begin sender_idle_pct = 20; stall_pct = 20; end
			endcase
			if (phase == 0)
				hold_requests++;
			@(negedge clk);
			if (phase == 0)
				fill_and_drain();
			while (items_sent < 25 + (phase + 1) * ITEMS_PER_PHASE) begin
				kind  = $urandom_range(99);
				burst = $urandom_range(1, 24);
				if (kind < 45) begin
					repeat (burst) send_word(CMD_INSERT, pick_stamp());
				end else if (kind < 80) begin
					repeat (burst) send_word(CMD_POP, pick_stamp());
				end else if (kind < 85) begin
					send_word(CMD_CLEAR, pick_stamp());
				end else if (kind < 90) begin
					send_word(CMD_INSERT, NO_STAMP);
				end else begin
					send_word(2'($urandom_range(3)), {$urandom, $urandom});
				end
			end
			wait_for_results();
		end

		wait_for_results();
		repeat (20) @(negedge clk);
		if (fail_count == 0 && pending_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/stq_pkg.sv
rtl/stq_cell.sv
rtl/sorted_timestamp_queue_core.sv
rtl/stq_checker.sv
dv/sorted_timestamp_queue_checker.sv
dv/sorted_timestamp_queue_core_tb.sv
